// ===== sv/r2p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package r2p_pkg;

    // iteration count and word widths
    localparam int CORDIC_STEPS = 18;
    localparam int ATAN_ENTRIES = 24;
    localparam int IN_W         = 16;
    localparam int FRAC_XY      = 16;
    localparam int XY_W         = 35;
    localparam int Z_W          = 32;
    localparam int MAG_W        = 16;
    localparam int ANG_W        = 20;
    localparam int FMT_W        = 2;

    // angle in 2^-28 rad, gain and degree scale
    localparam logic signed [Z_W-1:0] HALF_PI_Z       = 32'sd421657428;
    localparam int                    GAIN_W          = 30;
    localparam logic [GAIN_W-1:0]     INV_GAIN_Q30    = 30'd652032874;
    localparam int                    DEG_W           = 31;
    localparam logic signed [DEG_W-1:0] DEG_PER_RAD_Q24 = 31'sd961263669;

    // output angle codes
    localparam logic signed [ANG_W-1:0] PI_RAD_CODE   = 20'sd205887;
    localparam logic signed [ANG_W-1:0] TURN_RAD_CODE = 20'sd411775;
    localparam logic signed [ANG_W-1:0] PI_DEG_CODE   = 20'sd46080;
    localparam logic signed [ANG_W-1:0] TURN_DEG_CODE = 20'sd92160;

    // angle format codes
    localparam logic [FMT_W-1:0] FMT_RAD_SIGNED = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RAD_TURN   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_DEG_SIGNED = 2'd2;
    localparam logic [FMT_W-1:0] FMT_DEG_TURN   = 2'd3;

    typedef struct packed {
        logic signed [IN_W-1:0] x_coord;
        logic signed [IN_W-1:0] y_coord;
    } vec_beat_t;

    typedef struct packed {
        logic        [MAG_W-1:0] magnitude;
        logic signed [ANG_W-1:0] angle;
    } polar_beat_t;

    // working vector between the pipeline sections
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } cordic_vec_t;

    // atan(2^-i) in 2^-28 rad
    function automatic logic [Z_W-1:0] atan_at(input int unsigned idx);
        logic [Z_W-1:0] val;
        case (idx)
            0:       val = 32'd210828714;
            1:       val = 32'd124459457;
            2:       val = 32'd65760959;
            3:       val = 32'd33381290;
            4:       val = 32'd16755422;
            5:       val = 32'd8385879;
            6:       val = 32'd4193963;
            7:       val = 32'd2097109;
            8:       val = 32'd1048571;
            9:       val = 32'd524287;
            10:      val = 32'd262144;
            11:      val = 32'd131072;
            12:      val = 32'd65536;
            13:      val = 32'd32768;
            14:      val = 32'd16384;
            15:      val = 32'd8192;
            16:      val = 32'd4096;
            17:      val = 32'd2048;
            18:      val = 32'd1024;
            19:      val = 32'd512;
            20:      val = 32'd256;
            21:      val = 32'd128;
            22:      val = 32'd64;
            23:      val = 32'd32;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/r2p_prerot.sv =====
`timescale 1ns / 1ps
`default_nettype none

module r2p_prerot (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  r2p_pkg::vec_beat_t  vec,
    output logic                out_valid,
    output r2p_pkg::cordic_vec_t out_vec
);
    import r2p_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cordic_vec_t            vec_next;
    cordic_vec_t            vec_reg;
    logic                   valid_reg;

    assign xs = {{(XY_W-IN_W-FRAC_XY){vec.x_coord[IN_W-1]}}, vec.x_coord, {FRAC_XY{1'b0}}};
    assign ys = {{(XY_W-IN_W-FRAC_XY){vec.y_coord[IN_W-1]}}, vec.y_coord, {FRAC_XY{1'b0}}};

    // fold the left half plane into the right one by a quarter turn
    always_comb
    begin
        vec_next.x    = xs;
        vec_next.y    = ys;
        vec_next.z    = '0;
        vec_next.zero = (vec.x_coord == '0) && (vec.y_coord == '0);
        if (xs[XY_W-1])
        begin
            if (!ys[XY_W-1])
            begin
                vec_next.x = ys;
                vec_next.y = -xs;
                vec_next.z = HALF_PI_Z;
            end
            else
            begin
                vec_next.x = -ys;
                vec_next.y = xs;
                vec_next.z = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== sv/r2p_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module r2p_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  r2p_pkg::cordic_vec_t in_vec,
    output logic                 out_valid,
    output r2p_pkg::cordic_vec_t out_vec
);
    import r2p_pkg::*;

    localparam int N_ITER = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    cordic_vec_t       stage_reg  [N_ITER];
    cordic_vec_t       stage_next [N_ITER];
    logic [N_ITER-1:0] valid_reg;

    // one shift-and-add micro-rotation per stage, driving y towards zero
    always_comb
    begin
        cordic_vec_t            src;
        logic signed [XY_W-1:0] xsh;
        logic signed [XY_W-1:0] ysh;
        logic signed [Z_W-1:0]  da;
        for (int i = 0; i < N_ITER; i++)
        begin
            if (i == 0)
            begin
                src = in_vec;
            end
            else
            begin
                src = stage_reg[i-1];
            end
            xsh = $signed(src.x) >>> i;
            ysh = $signed(src.y) >>> i;
            da  = $signed(atan_at(i));
            stage_next[i] = src;
            if (!src.y[XY_W-1])
            begin
                stage_next[i].x = src.x + ysh;
                stage_next[i].y = src.y - xsh;
                stage_next[i].z = src.z + da;
            end
            else
            begin
                stage_next[i].x = src.x - ysh;
                stage_next[i].y = src.y + xsh;
                stage_next[i].z = src.z - da;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[N_ITER-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N_ITER; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[N_ITER-1];
    assign out_vec   = stage_reg[N_ITER-1];

endmodule

`default_nettype wire

// ===== sv/r2p_post.sv =====
`timescale 1ns / 1ps
`default_nettype none

module r2p_post (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [r2p_pkg::FMT_W-1:0]   angle_format,
    input  logic                        in_valid,
    input  r2p_pkg::cordic_vec_t        in_vec,
    output logic                        out_valid,
    output r2p_pkg::polar_beat_t        out_beat
);
    import r2p_pkg::*;

    localparam int XU_W       = XY_W - 1;
    localparam int LO_W       = 17;
    localparam int HI_W       = XU_W - LO_W;
    localparam int PL_W       = LO_W + GAIN_W;
    localparam int PH_W       = HI_W + GAIN_W;
    localparam int SUM_W      = PH_W + LO_W + 1;
    localparam int MAG_SHIFT  = 46;
    localparam int DP_W       = Z_W + DEG_W;
    localparam int DEG_SHIFT  = 44;
    localparam int RAD_SHIFT  = 12;
    localparam int AD_W       = DP_W + 1 - DEG_SHIFT;
    localparam int AR_W       = Z_W + 1 - RAD_SHIFT;
    localparam int A_W        = (AD_W > AR_W) ? AD_W : AR_W;
    localparam int MW_W       = SUM_W - MAG_SHIFT;

    // first stage: products
    logic [XU_W-1:0]          xu;
    logic [PH_W-1:0]          prod_h_next;
    logic [PL_W-1:0]          prod_l_next;
    logic signed [DP_W-1:0]   deg_next;
    logic [PH_W-1:0]          prod_h_reg;
    logic [PL_W-1:0]          prod_l_reg;
    logic signed [DP_W-1:0]   deg_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     zero_reg;
    logic                     valid_a_reg;

    // second stage: rounding and formatting
    logic [SUM_W-1:0]         mag_sum;
    logic [MW_W-1:0]          mag_wide;
    logic [MAG_W-1:0]         mag_sat;
    logic signed [DP_W:0]     deg_round;
    logic signed [Z_W:0]      rad_round;
    logic signed [A_W-1:0]    ang_raw;
    logic signed [A_W-1:0]    ang_lim;
    logic signed [A_W-1:0]    ang_clamp;
    logic signed [ANG_W-1:0]  ang_fmt;
    logic                     is_deg;
    logic                     is_turn;
    polar_beat_t              beat_next;
    polar_beat_t              beat_reg;
    logic                     valid_b_reg;

    assign xu = in_vec.x[XY_W-1] ? '0 : in_vec.x[XU_W-1:0];

    // the wide gain product is split in two halves of x
    assign prod_h_next = PH_W'(xu[XU_W-1:LO_W]) * PH_W'(INV_GAIN_Q30);
    assign prod_l_next = PL_W'(xu[LO_W-1:0]) * PL_W'(INV_GAIN_Q30);
    assign deg_next    = DP_W'(in_vec.z) * DP_W'(DEG_PER_RAD_Q24);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_h_reg <= prod_h_next;
            prod_l_reg <= prod_l_next;
            deg_reg    <= deg_next;
            z_reg      <= in_vec.z;
            zero_reg   <= in_vec.zero;
        end
    end

    assign is_deg  = angle_format inside {FMT_DEG_SIGNED, FMT_DEG_TURN};
    assign is_turn = angle_format inside {FMT_RAD_TURN, FMT_DEG_TURN};

    always_comb
    begin
        mag_sum   = {1'b0, prod_h_reg, {LO_W{1'b0}}} + SUM_W'(prod_l_reg)
                    + (SUM_W'(1) << (MAG_SHIFT - 1));
        mag_wide  = mag_sum[SUM_W-1:MAG_SHIFT];
        mag_sat   = (mag_wide > MW_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : mag_wide[MAG_W-1:0];

        deg_round = (DP_W+1)'(deg_reg) + ((DP_W+1)'(1) <<< (DEG_SHIFT - 1));
        rad_round = (Z_W+1)'(z_reg) + ((Z_W+1)'(1) <<< (RAD_SHIFT - 1));
        if (is_deg)
        begin
            ang_raw = A_W'($signed(deg_round[DP_W:DEG_SHIFT]));
            ang_lim = A_W'(PI_DEG_CODE);
        end
        else
        begin
            ang_raw = A_W'($signed(rad_round[Z_W:RAD_SHIFT]));
            ang_lim = A_W'(PI_RAD_CODE);
        end

        if (ang_raw > ang_lim)
        begin
            ang_clamp = ang_lim;
        end
        else if (ang_raw < -ang_lim)
        begin
            ang_clamp = -ang_lim;
        end
        else
        begin
            ang_clamp = ang_raw;
        end

        ang_fmt = ang_clamp[ANG_W-1:0];
        if (is_turn && ang_clamp[A_W-1])
        begin
            ang_fmt = ang_clamp[ANG_W-1:0] + (is_deg ? TURN_DEG_CODE : TURN_RAD_CODE);
        end

        beat_next.magnitude = mag_sat;
        beat_next.angle     = ang_fmt;
        if (zero_reg)
        begin
            beat_next.magnitude = '0;
            beat_next.angle     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

// ===== sv/rectangular_to_polar.sv =====
// pipeline: an accepted input beat passes through 1 fold stage, one stage per cordic
//   iteration, 1 multiply stage and 1 rounding/output stage on the way to its result beat
// throughput: one beat per cycle; the whole pipeline advances together and only
//   holds while the output register carries a beat that is stalled
// reset: rst_n clears every valid bit and sets angle_format to 0 (signed radians)
`timescale 1ns / 1ps
`default_nettype none

module rectangular_to_polar (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       format_we,
    input  logic [r2p_pkg::FMT_W-1:0]  format_wdata,
    // input vector channel
    input  logic                       vec_valid,
    output logic                       vec_stall,
    input  r2p_pkg::vec_beat_t         vec,
    // polar result channel
    output logic                       polar_valid,
    input  logic                       polar_stall,
    output r2p_pkg::polar_beat_t       polar
);
    import r2p_pkg::*;

    logic [FMT_W-1:0] angle_format_reg;
    logic             adv;
    logic             fold_valid;
    cordic_vec_t      fold_vec;
    logic             rot_valid;
    cordic_vec_t      rot_vec;

    // angle format register; write it only while the pipe is empty (the block does not enforce this)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_format_reg <= FMT_RAD_SIGNED;
        end
        else if (format_we)
        begin
            angle_format_reg <= format_wdata;
        end
    end

    // every stage moves on unless the output beat is held by the sink;
    // bubbles travel as cleared valid bits
    assign adv       = !(polar_valid && polar_stall);
    assign vec_stall = !adv;

    // quadrant fold: left half plane turned by a quarter turn
    r2p_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vec_valid),
        .vec       (vec),
        .out_valid (fold_valid),
        .out_vec   (fold_vec)
    );

    // vectoring iterations, one register stage each
    r2p_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fold_valid),
        .in_vec    (fold_vec),
        .out_valid (rot_valid),
        .out_vec   (rot_vec)
    );

    // gain correction, angle scaling, clamp and wrap; holds the output register
    r2p_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .angle_format (angle_format_reg),
        .in_valid     (rot_valid),
        .in_vec       (rot_vec),
        .out_valid    (polar_valid),
        .out_beat     (polar)
    );

    // full-turn formats never give a negative angle
    ap_turn_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && (angle_format_reg == FMT_RAD_TURN || angle_format_reg == FMT_DEG_TURN)
        |-> !polar.angle[ANG_W-1])
        else $error("negative angle in a full-turn format");

    // signed radian results stay inside the half-turn limits
    ap_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && angle_format_reg == FMT_RAD_SIGNED
        |-> ($signed(polar.angle) <= PI_RAD_CODE) && ($signed(polar.angle) >= -PI_RAD_CODE))
        else $error("radian angle out of range");

    // signed degree results stay inside the half-turn limits
    ap_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && angle_format_reg == FMT_DEG_SIGNED
        |-> ($signed(polar.angle) <= PI_DEG_CODE) && ($signed(polar.angle) >= -PI_DEG_CODE))
        else $error("degree angle out of range");

    // only the zero vector rounds to zero length, and it carries angle zero
    ap_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && polar.magnitude == '0 |-> polar.angle == '0)
        else $error("zero magnitude with non-zero angle");

endmodule

`default_nettype wire

// ===== dv/tb_rectangular_to_polar.sv =====
`timescale 1ns / 1ps

import r2p_pkg::*;

// one predicted result, with the vector and the format it came from
typedef struct {
    int                 x_src;
    int                 y_src;
    logic [FMT_W-1:0]   fmt;
    int                 magnitude;
    int                 angle;
} polar_expect_t;

class polar_scoreboard;

    // results may sit up to this many lsb off the prediction
    localparam int TOL_LSB    = 2;
    localparam int PRINT_CAP  = 200;

    logic [FMT_W-1:0] angle_format = FMT_RAD_SIGNED;
    polar_expect_t    pending_polar[$];
    int               mismatches = 0;

    // atan(2^-i) in 2^-28 rad
    longint atan_step[24] = '{
        210828714, 124459457, 65760959, 33381290,
        16755422,  8385879,   4193963,  2097109,
        1048571,   524287,    262144,   131072,
        65536,     32768,     16384,    8192,
        4096,      2048,      1024,     512,
        256,       128,       64,       32
    };

    function int pending_count();
        return pending_polar.size();
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // cordic vectoring on 64-bit integers, rounded as the block rounds
    function polar_expect_t to_polar(vec_beat_t v);
        longint x, y, z, t, xs, ys, mag, ang, lim, turn;
        longint quarter, gain, deg_scale;
        polar_expect_t e;
        bit in_deg, wrap;
        x = v.x_coord;
        y = v.y_coord;
        e.x_src = int'(x);
        e.y_src = int'(y);
        e.fmt = angle_format;
        e.magnitude = 0;
        e.angle = 0;
        in_deg = (angle_format == FMT_DEG_SIGNED) || (angle_format == FMT_DEG_TURN);
        wrap = (angle_format == FMT_RAD_TURN) || (angle_format == FMT_DEG_TURN);
        quarter = HALF_PI_Z;
        gain = INV_GAIN_Q30;
        deg_scale = DEG_PER_RAD_Q24;
        if (x == 0 && y == 0)
            return e;
        x = x * (longint'(1) <<< FRAC_XY);
        y = y * (longint'(1) <<< FRAC_XY);
        z = 0;
        // fold the left half plane over by a quarter turn
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = quarter;
            end
            else
            begin
                x = -y;
                y = t;
                z = -quarter;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step[i];
            end
        end
        if (x < 0)
            x = 0;
        mag = (x * gain + (longint'(1) <<< 45)) >>> 46;
        if (mag > 65535)
            mag = 65535;
        if (in_deg)
        begin
            ang = (z * deg_scale + (longint'(1) <<< 43)) >>> 44;
            lim = PI_DEG_CODE;
            turn = TURN_DEG_CODE;
        end
        else
        begin
            ang = (z + (longint'(1) <<< 11)) >>> 12;
            lim = PI_RAD_CODE;
            turn = TURN_RAD_CODE;
        end
        if (ang > lim)
            ang = lim;
        if (ang < -lim)
            ang = -lim;
        if (wrap && ang < 0)
            ang = ang + turn;
        e.magnitude = int'(mag);
        e.angle = int'(ang);
        return e;
    endfunction

    function void note_vector(vec_beat_t v);
        pending_polar.push_back(to_polar(v));
    endfunction

    task check_polar(polar_beat_t p);
        polar_expect_t           e;
        logic signed [ANG_W-1:0] got_ang;
        int                      mag_err, ang_err, turn;
        got_ang = p.angle;
        if (pending_polar.size() == 0)
        begin
            report_mismatch($sformatf("polar beat with nothing pending: mag %0d angle %0d",
                                      p.magnitude, got_ang));
            return;
        end
        e = pending_polar.pop_front();
        mag_err = int'(p.magnitude) - e.magnitude;
        ang_err = got_ang - e.angle;
        // turn formats: an angle just below a full turn is next to zero
        if (e.fmt == FMT_RAD_TURN || e.fmt == FMT_DEG_TURN)
        begin
            turn = (e.fmt == FMT_DEG_TURN) ? int'(TURN_DEG_CODE) : int'(TURN_RAD_CODE);
            if (ang_err > turn / 2)
                ang_err = ang_err - turn;
            else if (ang_err < -turn / 2)
                ang_err = ang_err + turn;
        end
        if (mag_err > TOL_LSB || mag_err < -TOL_LSB)
            report_mismatch($sformatf("(%0d,%0d) fmt %0d magnitude %0d, predicted %0d",
                                      e.x_src, e.y_src, e.fmt, p.magnitude, e.magnitude));
        if (ang_err > TOL_LSB || ang_err < -TOL_LSB)
            report_mismatch($sformatf("(%0d,%0d) fmt %0d angle %0d, predicted %0d",
                                      e.x_src, e.y_src, e.fmt, got_ang, e.angle));
    endtask

    task check_drained();
        if (pending_polar.size() != 0)
            report_mismatch($sformatf("%0d polar beats never arrived", pending_polar.size()));
    endtask

endclass

module tb_rectangular_to_polar;

    // pipeline depth given for the block, plus a margin for the final wait
    localparam int PIPE_LATENCY = 21;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 230;
    localparam int HOLD_ITEMS   = 120;
    localparam int TAIL_ITEMS   = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        format_we = 1'b0;
    logic [FMT_W-1:0] format_wdata = FMT_RAD_SIGNED;
    logic        vec_valid = 1'b0;
    logic        vec_stall;
    vec_beat_t   vec = '0;
    logic        polar_valid;
    logic        polar_stall = 1'b0;
    polar_beat_t polar;

    polar_scoreboard polar_sb = new();

    // flags shared between the sender and the receiver
    bit hold_req = 1'b0;
    bit calm     = 1'b0;

    // corner vectors, all run under the reset format
    int corner_xy[20][2] = '{
        '{0, 0},           '{1, 0},           '{0, 1},          '{0, -1},
        '{-1, 0},          '{32767, 0},       '{-32768, 0},     '{0, 32767},
        '{0, -32768},      '{32767, 32767},   '{-32768, -32768}, '{-32768, 32767},
        '{32767, -32768},  '{-32768, -1},     '{-32768, 1},     '{-1, -1},
        '{-1, 1},          '{1, -1},          '{12345, -6789},  '{-20000, 77}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rectangular_to_polar dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .format_we    (format_we),
        .format_wdata (format_wdata),
        .vec_valid    (vec_valid),
        .vec_stall    (vec_stall),
        .vec          (vec),
        .polar_valid  (polar_valid),
        .polar_stall  (polar_stall),
        .polar        (polar)
    );

    // result side: every accepted beat goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && polar_valid && !polar_stall)
            polar_sb.check_polar(polar);
    end

    // receiver stall pattern: each pass sets polar_stall, then waits on the clock
    initial
    begin : result_stall
        forever
        begin
            if (hold_req)
            begin
                // long hold-off so the pipe fills and backs up to the input
                polar_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                polar_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            polar_stall <= 1'b0;
            if (calm)
                @(posedge clk);
            else
                repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // random vector with a bias towards axes, the fold boundary and tiny lengths
    function automatic vec_beat_t pick_vector();
        vec_beat_t v;
        int        mag;
        int        rim_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};
        v.x_coord = 16'($urandom);
        v.y_coord = 16'($urandom);
        case ($urandom_range(0, 15))
            0: v.x_coord = '0;
            1: v.y_coord = '0;
            2:
            begin
                // close to the negative x axis, where the angle clamps or wraps
                v.x_coord = 16'(-int'($urandom_range(1, 32768)));
                v.y_coord = 16'(int'($urandom_range(0, 6)) - 3);
            end
            3:
            begin
                v.x_coord = 16'(int'($urandom_range(0, 8)) - 4);
                v.y_coord = 16'(int'($urandom_range(0, 8)) - 4);
            end
            4:
            begin
                v.x_coord = 16'(rim_vals[$urandom_range(0, 5)]);
                v.y_coord = 16'(rim_vals[$urandom_range(0, 5)]);
            end
            5:
            begin
                mag = $urandom_range(1, 32767);
                v.x_coord = 16'($urandom_range(0, 1) ? mag : -mag);
                v.y_coord = 16'($urandom_range(0, 1) ? mag : -mag);
            end
            default: ;
        endcase
        return v;
    endfunction

    // offer one beat and hold it until the block takes it
    task send_vector(vec_beat_t v);
        vec <= v;
        vec_valid <= 1'b1;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        polar_sb.note_vector(v);
    endtask

    task run_vectors(int count, bit idle);
        for (int k = 0; k < count; k++)
        begin
            send_vector(pick_vector());
            if (idle && $urandom_range(0, 3) == 0)
            begin
                vec_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
        vec_valid <= 1'b0;
    endtask

    // format changes only once the pipe is empty
    task set_angle_format(logic [FMT_W-1:0] fmt);
        while (polar_sb.pending_count() != 0)
            @(posedge clk);
        format_we <= 1'b1;
        format_wdata <= fmt;
        @(posedge clk);
        format_we <= 1'b0;
        polar_sb.angle_format = fmt;
    endtask

    initial
    begin : stimulus
        vec_beat_t v;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under signed radians, the reset format
        for (int k = 0; k < 20; k++)
        begin
            v.x_coord = 16'(corner_xy[k][0]);
            v.y_coord = 16'(corner_xy[k][1]);
            send_vector(v);
        end
        vec_valid <= 1'b0;

        set_angle_format(FMT_RAD_TURN);
        run_vectors(PHASE_ITEMS, 1'b1);
        set_angle_format(FMT_DEG_SIGNED);
        run_vectors(PHASE_ITEMS, 1'b1);
        set_angle_format(FMT_DEG_TURN);
        run_vectors(PHASE_ITEMS / 2, 1'b1);
        // sender keeps offering back to back while the receiver holds off
        hold_req = 1'b1;
        run_vectors(HOLD_ITEMS, 1'b0);
        run_vectors(PHASE_ITEMS / 2, 1'b1);
        set_angle_format(FMT_RAD_SIGNED);
        run_vectors(PHASE_ITEMS, 1'b1);
        set_angle_format(FMT_DEG_TURN);
        run_vectors(PHASE_ITEMS, 1'b1);
        set_angle_format(FMT_RAD_TURN);
        run_vectors(PHASE_ITEMS, 1'b1);

        // closing stretch with no idling on either side
        set_angle_format(FMT_DEG_SIGNED);
        calm = 1'b1;
        run_vectors(TAIL_ITEMS, 1'b0);

        for (int w = 0; w < 20000 && polar_sb.pending_count() != 0; w++)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        polar_sb.check_drained();

        if (polar_sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
